// ----- design/mmis_pkg.sv -----
// Shared constants, instruction codes and transaction types of the mini-MIPS step block.
package mmis_pkg;

  localparam int unsigned DEF_DATA_WORDS = 256;
  localparam int unsigned DEF_DATA_WIDTH = 32;
  localparam int unsigned RegCount       = 8;
  localparam int unsigned RegIdxW        = 3;
  localparam int unsigned PcW            = 8;
  localparam int unsigned ImmW           = 6;
  localparam int unsigned TgtW           = 7;
  localparam int unsigned OutW           = 32;
  localparam int unsigned QueueDepth     = 2;

  localparam logic [3:0] OPC_RTYPE = 4'd0;
  localparam logic [3:0] OPC_JUMP  = 4'd2;
  localparam logic [3:0] OPC_ADDI  = 4'd4;
  localparam logic [3:0] OPC_BEQ   = 4'd8;
  localparam logic [3:0] OPC_LW    = 4'd11;
  localparam logic [3:0] OPC_SW    = 4'd15;

  localparam logic [2:0] FN_ADD = 3'd0;
  localparam logic [2:0] FN_SUB = 3'd2;
  localparam logic [2:0] FN_AND = 3'd4;
  localparam logic [2:0] FN_OR  = 3'd5;

  typedef enum logic [3:0] {
    CLS_ADD  = 4'd0,
    CLS_SUB  = 4'd1,
    CLS_AND  = 4'd2,
    CLS_OR   = 4'd3,
    CLS_ADDI = 4'd4,
    CLS_LW   = 4'd5,
    CLS_SW   = 4'd6,
    CLS_BEQ  = 4'd7,
    CLS_JUMP = 4'd8,
    CLS_BAD  = 4'd9
  } cls_e;

  typedef struct packed {
    cls_e                cls;
    logic [RegIdxW-1:0]  rs;
    logic [RegIdxW-1:0]  rt;
    logic [RegIdxW-1:0]  rd;
    logic [ImmW-1:0]     imm;
    logic [TgtW-1:0]     target;
  } dec_t;

  typedef struct packed {
    logic [PcW-1:0]      next_pc;
    logic                reg_write;
    logic [RegIdxW-1:0]  reg_index;
    logic [OutW-1:0]     reg_value;
    logic                mem_write;
    logic [PcW-1:0]      mem_address;
    logic [OutW-1:0]     mem_value;
    logic                branch_taken;
    logic                illegal_code;
  } res_t;

endpackage

// ----- design/mini_mips_instruction_step.sv -----
// Top level of the mini-MIPS instruction step block: front end, back end and result queue.
//
//   Channel   Direction  Handshake           Payload
//   --------  ---------  ------------------  ------------------------------------------
//   input     in         push / full         instruction_word_i (16 bits)
//   result    out        empty / pop         next_pc_o, reg_write_o, reg_index_o,
//                                            reg_value_o, mem_write_o, mem_address_o,
//                                            mem_value_o, branch_taken_o, illegal_code_o
//
// In the back end an instruction goes through a register file read, then execute and write
// back; a load adds a step because the data memory port adds a registered read.
// The back end takes a new instruction only once it has finished the last one.
// A result enters the result queue at the execute step (at the load step for lw) and is
// on the result ports once it reaches the head of that queue.
// Reset clears the program counter and the written-flags of the register file and data
// memory, so both read as zero at once; there is no clearing pass.
// Until full, the input queue takes transactions while the back end works or results wait.
module mini_mips_instruction_step
  import mmis_pkg::*;
#(
  parameter int unsigned DATA_WORDS = DEF_DATA_WORDS,
  parameter int unsigned DATA_WIDTH = DEF_DATA_WIDTH
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // Instruction channel.
  input  logic               push,
  output logic               full,
  input  logic [15:0]        instruction_word_i,
  // Result channel.
  output logic               empty,
  input  logic               pop,
  output logic [7:0]         next_pc_o,
  output logic               reg_write_o,
  output logic [2:0]         reg_index_o,
  output logic signed [31:0] reg_value_o,
  output logic               mem_write_o,
  output logic [7:0]         mem_address_o,
  output logic signed [31:0] mem_value_o,
  output logic               branch_taken_o,
  output logic               illegal_code_o
);

  // Decoded instructions wait between the front and back ends.
  dec_t item;
  logic item_empty;
  logic item_pop;

  // Finished results wait in the output queue until popped.
  logic out_full;
  logic res_push;
  res_t res;
  logic [$bits(res_t)-1:0] out_rdata;
  res_t out_res;

  mmis_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .instr_i (instruction_word_i),
    .full_o  (full),
    .pop_i   (item_pop),
    .item_o  (item),
    .empty_o (item_empty)
  );

  mmis_back #(
    .DATA_WORDS(DATA_WORDS),
    .DATA_WIDTH(DATA_WIDTH)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_i       (item),
    .item_empty_i (item_empty),
    .item_pop_o   (item_pop),
    .out_full_i   (out_full),
    .res_push_o   (res_push),
    .res_o        (res)
  );

  // The back end only starts an instruction when this queue has room, so a
  // pushed result is never dropped.
  mmis_fifo #(
    .WIDTH($bits(res_t)),
    .DEPTH(QueueDepth)
  ) u_out_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .wdata_i (res),
    .full_o  (out_full),
    .pop_i   (pop),
    .rdata_o (out_rdata),
    .empty_o (empty)
  );

  assign out_res        = res_t'(out_rdata);
  assign next_pc_o      = out_res.next_pc;
  assign reg_write_o    = out_res.reg_write;
  assign reg_index_o    = out_res.reg_index;
  assign reg_value_o    = out_res.reg_value;
  assign mem_write_o    = out_res.mem_write;
  assign mem_address_o  = out_res.mem_address;
  assign mem_value_o    = out_res.mem_value;
  assign branch_taken_o = out_res.branch_taken;
  assign illegal_code_o = out_res.illegal_code;

endmodule

// ----- design/mmis_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module mmis_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned Aw = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [Aw-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [Aw-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- design/mmis_fifo.sv -----
// Small first-in first-out queue with registered storage.
module mmis_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             empty_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    cnt_d = cnt_q + CntW'(do_push) - CntW'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

// ----- design/mmis_front.sv -----
// Front end: takes instruction words, classifies them and queues the decoded form.
module mmis_front
  import mmis_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  logic [15:0] instr_i,
  output logic        full_o,
  input  logic        pop_i,
  output dec_t        item_o,
  output logic        empty_o
);

  dec_t                 dec;
  logic [$bits(dec_t)-1:0] q_rdata;

  always_comb begin
    dec.rs     = instr_i[11:9];
    dec.rt     = instr_i[8:6];
    dec.rd     = instr_i[5:3];
    dec.imm    = instr_i[5:0];
    dec.target = instr_i[6:0];
    unique case (instr_i[15:12])
      OPC_RTYPE: begin
        unique case (instr_i[2:0])
          FN_ADD:  dec.cls = CLS_ADD;
          FN_SUB:  dec.cls = CLS_SUB;
          FN_AND:  dec.cls = CLS_AND;
          FN_OR:   dec.cls = CLS_OR;
          default: dec.cls = CLS_BAD;
        endcase
      end
      OPC_ADDI: dec.cls = CLS_ADDI;
      OPC_LW:   dec.cls = CLS_LW;
      OPC_SW:   dec.cls = CLS_SW;
      OPC_BEQ:  dec.cls = CLS_BEQ;
      OPC_JUMP: dec.cls = CLS_JUMP;
      default:  dec.cls = CLS_BAD;
    endcase
  end

  mmis_fifo #(
    .WIDTH($bits(dec_t)),
    .DEPTH(QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push_i),
    .wdata_i (dec),
    .full_o  (full_o),
    .pop_i   (pop_i),
    .rdata_o (q_rdata),
    .empty_o (empty_o)
  );

  assign item_o = dec_t'(q_rdata);

endmodule

// ----- design/mmis_back.sv -----
// Back end: executes decoded instructions against the PC, register file and data memory.
module mmis_back
  import mmis_pkg::*;
#(
  parameter int unsigned DATA_WORDS = DEF_DATA_WORDS,
  parameter int unsigned DATA_WIDTH = DEF_DATA_WIDTH
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  dec_t item_i,
  input  logic item_empty_i,
  output logic item_pop_o,
  input  logic out_full_i,
  output logic res_push_o,
  output res_t res_o
);

  localparam int unsigned MemAw = (DATA_WORDS > 1) ? $clog2(DATA_WORDS) : 1;

  typedef enum logic [2:0] {
    BK_IDLE = 3'b001,
    BK_EXEC = 3'b010,
    BK_LOAD = 3'b100
  } bk_state_e;

  bk_state_e             state_q, state_d;
  dec_t                  cur_q;
  logic [PcW-1:0]        pc_q;
  logic [RegCount-1:0]   rf_vld_q;
  logic [DATA_WORDS-1:0] mem_vld_q;
  logic                  a_vld_q, b_vld_q, ld_vld_q;
  res_t                  res_q;

  logic                  start;
  logic [DATA_WIDTH-1:0] ra_data, rb_data, opa, opb, a_imm, exec_wval, ld_data;
  logic [PcW-1:0]        addr;
  logic                  in_range;
  logic [MemAw-1:0]      mem_idx;
  logic [DATA_WIDTH-1:0] mem_rdata;
  res_t                  exec_res, load_res;

  logic                  rf_we;
  logic [RegIdxW-1:0]    rf_waddr;
  logic [DATA_WIDTH-1:0] rf_wdata;
  logic                  mem_we;

  // An instruction starts only when the result queue has a free slot; only one
  // instruction is in flight, so that slot is still free when the result arrives.
  assign start      = (state_q == BK_IDLE) && !item_empty_i && !out_full_i;
  assign item_pop_o = start;

  mmis_ram #(.WIDTH(DATA_WIDTH), .DEPTH(RegCount)) u_rf_a (
    .clk_i   (clk_i),
    .we_i    (rf_we),
    .waddr_i (rf_waddr),
    .wdata_i (rf_wdata),
    .raddr_i (item_i.rs),
    .rdata_o (ra_data)
  );

  mmis_ram #(.WIDTH(DATA_WIDTH), .DEPTH(RegCount)) u_rf_b (
    .clk_i   (clk_i),
    .we_i    (rf_we),
    .waddr_i (rf_waddr),
    .wdata_i (rf_wdata),
    .raddr_i (item_i.rt),
    .rdata_o (rb_data)
  );

  mmis_ram #(.WIDTH(DATA_WIDTH), .DEPTH(DATA_WORDS)) u_dmem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_idx),
    .wdata_i (opb),
    .raddr_i (mem_idx),
    .rdata_o (mem_rdata)
  );

  // Entries never written read as zero.
  assign opa      = a_vld_q ? ra_data : '0;
  assign opb      = b_vld_q ? rb_data : '0;
  assign a_imm    = opa + DATA_WIDTH'(cur_q.imm);
  assign addr     = a_imm[PcW-1:0];
  assign in_range = ({1'b0, addr} < (PcW + 1)'(DATA_WORDS));
  assign mem_idx  = addr[MemAw-1:0];
  assign ld_data  = ld_vld_q ? mem_rdata : '0;

  always_comb begin
    exec_res         = '0;
    exec_res.next_pc = pc_q + 8'd1;
    exec_wval        = '0;
    unique case (cur_q.cls)
      CLS_ADD: exec_wval = opa + opb;
      CLS_SUB: exec_wval = opa - opb;
      CLS_AND: exec_wval = opa & opb;
      CLS_OR:  exec_wval = opa | opb;
      CLS_ADDI: exec_wval = a_imm;
      CLS_LW: begin
        exec_res.mem_address = addr;
        exec_res.reg_write   = 1'b1;
        exec_res.reg_index   = cur_q.rt;
      end
      CLS_SW: begin
        exec_res.mem_address = addr;
        if (in_range) begin
          exec_res.mem_write = 1'b1;
          exec_res.mem_value = OutW'($signed(opb));
        end
      end
      CLS_BEQ: begin
        if (opa == opb) begin
          exec_res.branch_taken = 1'b1;
          exec_res.next_pc      = pc_q + PcW'(cur_q.imm);
        end
      end
      CLS_JUMP: begin
        exec_res.branch_taken = 1'b1;
        exec_res.next_pc      = PcW'(cur_q.target);
      end
      default: exec_res.illegal_code = 1'b1;
    endcase
    if (cur_q.cls == CLS_ADD || cur_q.cls == CLS_SUB || cur_q.cls == CLS_AND ||
        cur_q.cls == CLS_OR) begin
      exec_res.reg_write = 1'b1;
      exec_res.reg_index = cur_q.rd;
      exec_res.reg_value = OutW'($signed(exec_wval));
    end else if (cur_q.cls == CLS_ADDI) begin
      exec_res.reg_write = 1'b1;
      exec_res.reg_index = cur_q.rt;
      exec_res.reg_value = OutW'($signed(exec_wval));
    end
  end

  always_comb begin
    load_res           = res_q;
    load_res.reg_value = OutW'($signed(ld_data));
  end

  assign res_push_o = ((state_q == BK_EXEC) && (cur_q.cls != CLS_LW)) ||
                      (state_q == BK_LOAD);
  assign res_o      = (state_q == BK_LOAD) ? load_res : exec_res;

  assign rf_we    = ((state_q == BK_EXEC) && exec_res.reg_write && (cur_q.cls != CLS_LW)) ||
                    (state_q == BK_LOAD);
  assign rf_waddr = (state_q == BK_LOAD) ? res_q.reg_index : exec_res.reg_index;
  assign rf_wdata = (state_q == BK_LOAD) ? ld_data : exec_wval;
  assign mem_we   = (state_q == BK_EXEC) && (cur_q.cls == CLS_SW) && in_range;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BK_IDLE: if (start) state_d = BK_EXEC;
      BK_EXEC: state_d = (cur_q.cls == CLS_LW) ? BK_LOAD : BK_IDLE;
      BK_LOAD: state_d = BK_IDLE;
      default: state_d = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= BK_IDLE;
      pc_q      <= '0;
      rf_vld_q  <= '0;
      mem_vld_q <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == BK_EXEC) begin
        pc_q <= exec_res.next_pc;
      end
      if (rf_we) begin
        rf_vld_q[rf_waddr] <= 1'b1;
      end
      if (mem_we) begin
        mem_vld_q[mem_idx] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start) begin
      cur_q   <= item_i;
      a_vld_q <= rf_vld_q[item_i.rs];
      b_vld_q <= rf_vld_q[item_i.rt];
    end
    if (state_q == BK_EXEC) begin
      res_q    <= exec_res;
      ld_vld_q <= in_range && mem_vld_q[mem_idx];
    end
  end

  a_push_has_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push_o |-> !out_full_i)
    else $error("result pushed while the result queue is full");

  a_load_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == BK_LOAD |=> state_q == BK_IDLE)
    else $error("load step not followed by idle");

  a_one_store: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(rf_we && mem_we))
    else $error("register and memory written in the same cycle");

  a_quiet_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push_o && !res_o.reg_write |-> res_o.reg_index == '0 && res_o.reg_value == '0)
    else $error("register fields not cleared when no register is written");

  a_pc_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != BK_EXEC |=> $stable(pc_q))
    else $error("program counter moved outside the execute step");

endmodule

// ----- tb/sv/testbench.sv -----
// Self-checking testbench for the mini-MIPS instruction step block.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import mmis_pkg::*;

  // Cycles without any accepted transaction before the run is declared hung. The slowest
  // stretch is a long receiver stall at 60 percent idling, far below this.
  localparam int unsigned HangLimit = 4000;

  // The architectural state tracker runs every instruction that enters the block on its
  // own copy of the program counter, register file and data memory. Each accepted
  // instruction leaves one outcome in the queue, and results from the block are matched
  // against the oldest outcome still queued.
  class arch_state_tracker;
    logic [PcW-1:0]  pc;
    logic [OutW-1:0] regs[RegCount];
    logic [OutW-1:0] dmem[DEF_DATA_WORDS];
    res_t            outcome_q[$];
    int unsigned     mismatches;

    function new();
      pc = '0;
      foreach (regs[i]) regs[i] = '0;
      foreach (dmem[i]) dmem[i] = '0;
      mismatches = 0;
    endfunction

    function int unsigned pending();
      return outcome_q.size();
    endfunction

    // Execute one instruction and queue the result the block should report for it.
    function void retire(logic [15:0] word);
      logic [3:0]      opcode;
      logic [2:0]      rs, rt, rd, funct;
      logic [5:0]      imm;
      logic [OutW-1:0] a, b, sum;
      res_t            r;
      opcode = word[15:12];
      rs     = word[11:9];
      rt     = word[8:6];
      rd     = word[5:3];
      funct  = word[2:0];
      imm    = word[5:0];
      a      = regs[rs];
      b      = regs[rt];
      sum    = a + OutW'(imm);
      r      = '0;
      r.next_pc = pc + 8'd1;
      case (opcode)
        OPC_RTYPE: begin
          r.reg_write = 1'b1;
          r.reg_index = rd;
          case (funct)
            FN_ADD:  r.reg_value = a + b;
            FN_SUB:  r.reg_value = a - b;
            FN_AND:  r.reg_value = a & b;
            FN_OR:   r.reg_value = a | b;
            default: begin
              r.reg_write    = 1'b0;
              r.reg_index    = '0;
              r.illegal_code = 1'b1;
            end
          endcase
        end
        OPC_ADDI: begin
          r.reg_write = 1'b1;
          r.reg_index = rt;
          r.reg_value = sum;
        end
        OPC_LW: begin
          // The load address wraps at 256, so every address hits the full-size memory.
          r.mem_address = sum[7:0];
          r.reg_write   = 1'b1;
          r.reg_index   = rt;
          r.reg_value   = dmem[sum[7:0]];
        end
        OPC_SW: begin
          r.mem_address    = sum[7:0];
          r.mem_write      = 1'b1;
          r.mem_value      = b;
          dmem[sum[7:0]]   = b;
        end
        OPC_BEQ: begin
          if (a == b) begin
            r.branch_taken = 1'b1;
            r.next_pc      = pc + PcW'(imm);
          end
        end
        OPC_JUMP: begin
          r.branch_taken = 1'b1;
          r.next_pc      = PcW'(word[6:0]);
        end
        default: r.illegal_code = 1'b1;
      endcase
      if (r.reg_write) regs[r.reg_index] = r.reg_value;
      pc = r.next_pc;
      outcome_q.push_back(r);
    endfunction

    function void check_field(string name, logic [31:0] want, logic [31:0] seen);
      if (seen !== want) begin
        $error("%s mismatch: expected %0h, actual %0h", name, want, seen);
        mismatches++;
      end
    endfunction

    function void check_outcome(res_t got);
      res_t want;
      if (outcome_q.size() == 0) begin
        $error("result transaction with no instruction outstanding (next_pc %0h)",
               got.next_pc);
        mismatches++;
        return;
      end
      want = outcome_q.pop_front();
      check_field("next_pc",      32'(want.next_pc),      32'(got.next_pc));
      check_field("reg_write",    32'(want.reg_write),    32'(got.reg_write));
      check_field("reg_index",    32'(want.reg_index),    32'(got.reg_index));
      check_field("reg_value",    want.reg_value,         got.reg_value);
      check_field("mem_write",    32'(want.mem_write),    32'(got.mem_write));
      check_field("mem_address",  32'(want.mem_address),  32'(got.mem_address));
      check_field("mem_value",    want.mem_value,         got.mem_value);
      check_field("branch_taken", 32'(want.branch_taken), 32'(got.branch_taken));
      check_field("illegal_code", 32'(want.illegal_code), 32'(got.illegal_code));
    endfunction
  endclass

  // All block inputs start at known values; reset is held from time zero.
  logic               clk_i              = 1'b0;
  logic               rst_ni             = 1'b0;
  logic               push               = 1'b0;
  logic [15:0]        instruction_word_i = '0;
  logic               pop                = 1'b0;
  logic               full;
  logic               empty;
  logic [7:0]         next_pc_o;
  logic               reg_write_o;
  logic [2:0]         reg_index_o;
  logic signed [31:0] reg_value_o;
  logic               mem_write_o;
  logic [7:0]         mem_address_o;
  logic signed [31:0] mem_value_o;
  logic               branch_taken_o;
  logic               illegal_code_o;

  arch_state_tracker tracker;
  int unsigned       send_idle_pct = 12;
  int unsigned       recv_idle_pct = 60;
  int unsigned       quiet_cycles  = 0;

  mini_mips_instruction_step uut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .push               (push),
    .full               (full),
    .instruction_word_i (instruction_word_i),
    .empty              (empty),
    .pop                (pop),
    .next_pc_o          (next_pc_o),
    .reg_write_o        (reg_write_o),
    .reg_index_o        (reg_index_o),
    .reg_value_o        (reg_value_o),
    .mem_write_o        (mem_write_o),
    .mem_address_o      (mem_address_o),
    .mem_value_o        (mem_value_o),
    .branch_taken_o     (branch_taken_o),
    .illegal_code_o     (illegal_code_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // The receiver decides each cycle whether it takes a result. Pop may be high while the
  // block is empty; that is legal and simply moves nothing.
  always @(posedge clk_i) begin
    pop <= rst_ni && ($urandom_range(99) >= recv_idle_pct);
  end

  // Both channels are observed at the clock edge with the values that held just before
  // it, so the bookkeeping does not depend on the order of processes within the edge.
  // The same block runs the hang watchdog, which restarts whenever a transaction moves.
  always @(posedge clk_i) begin
    res_t got;
    if (rst_ni) begin
      if (push && !full) tracker.retire(instruction_word_i);
      if (pop && !empty) begin
        got.next_pc      = next_pc_o;
        got.reg_write    = reg_write_o;
        got.reg_index    = reg_index_o;
        got.reg_value    = reg_value_o;
        got.mem_write    = mem_write_o;
        got.mem_address  = mem_address_o;
        got.mem_value    = mem_value_o;
        got.branch_taken = branch_taken_o;
        got.illegal_code = illegal_code_o;
        tracker.check_outcome(got);
      end
      if ((push && !full) || (pop && !empty)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= HangLimit) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  function automatic logic [15:0] enc_r(logic [2:0] funct, logic [2:0] rs, logic [2:0] rt,
                                        logic [2:0] rd);
    return {OPC_RTYPE, rs, rt, rd, funct};
  endfunction

  function automatic logic [15:0] enc_i(logic [3:0] opcode, logic [2:0] rs, logic [2:0] rt,
                                        logic [5:0] imm);
    return {opcode, rs, rt, imm};
  endfunction

  // Mostly well-formed instructions with random fields, plus a share of undefined
  // functs, undefined opcodes and raw random words. About half of the branches compare
  // a register with itself so that taken branches are common.
  function automatic logic [15:0] random_instr();
    logic [15:0] w;
    logic [3:0]  op;
    logic [2:0]  fn;
    int unsigned pick;
    w    = 16'($urandom_range(16'hFFFF));
    pick = $urandom_range(99);
    if (pick < 14) begin
      w[15:12] = OPC_ADDI;
    end else if (pick < 30) begin
      case ($urandom_range(3))
        0:       fn = FN_ADD;
        1:       fn = FN_SUB;
        2:       fn = FN_AND;
        default: fn = FN_OR;
      endcase
      w[15:12] = OPC_RTYPE;
      w[2:0]   = fn;
    end else if (pick < 42) begin
      w[15:12] = OPC_LW;
    end else if (pick < 54) begin
      w[15:12] = OPC_SW;
    end else if (pick < 66) begin
      w[15:12] = OPC_BEQ;
      if ($urandom_range(1) == 1) w[8:6] = w[11:9];
    end else if (pick < 72) begin
      w[15:12] = OPC_JUMP;
    end else if (pick < 80) begin
      do fn = 3'($urandom_range(7));
      while (fn == FN_ADD || fn == FN_SUB || fn == FN_AND || fn == FN_OR);
      w[15:12] = OPC_RTYPE;
      w[2:0]   = fn;
    end else if (pick < 88) begin
      do op = 4'($urandom_range(15));
      while (op == OPC_RTYPE || op == OPC_JUMP || op == OPC_ADDI || op == OPC_BEQ ||
             op == OPC_LW || op == OPC_SW);
      w[15:12] = op;
    end
    return w;
  endfunction

  // Offer one instruction, optionally after some idle cycles, and return at the edge that
  // accepts it. Junk is driven on the word while push is low to show it is ignored.
  task automatic send_instr(logic [15:0] word);
    while ($urandom_range(99) < send_idle_pct) begin
      push               <= 1'b0;
      instruction_word_i <= 16'($urandom_range(16'hFFFF));
      @(posedge clk_i);
    end
    push               <= 1'b1;
    instruction_word_i <= word;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
  endtask

  // Directed opening: every operation, every funct, the immediate and target extremes,
  // wrapping arithmetic, a load from an address never stored, the address wrapping past
  // 255, register zero being written, taken and untaken branches, a branch to itself, and
  // the program counter wrapping at 256.
  task automatic run_directed();
    send_instr(enc_i(OPC_ADDI, 3'd0, 3'd1, 6'd63));   // r1 = 63
    send_instr(enc_i(OPC_ADDI, 3'd0, 3'd7, 6'd1));    // r7 = 1
    send_instr(enc_r(FN_SUB, 3'd0, 3'd7, 3'd6));      // r6 = all ones
    send_instr(enc_r(FN_ADD, 3'd6, 3'd7, 3'd5));      // wraps to zero
    send_instr(enc_r(FN_SUB, 3'd5, 3'd1, 3'd3));      // r3 = -63
    send_instr(enc_r(FN_AND, 3'd6, 3'd1, 3'd4));
    send_instr(enc_r(FN_OR,  3'd3, 3'd1, 3'd4));
    for (int f = 0; f < 8; f++) send_instr(enc_r(3'(f), 3'd6, 3'd1, 3'(f)));
    send_instr(16'h1FFF);                             // undefined opcodes
    send_instr(16'hE000);
    send_instr(enc_i(OPC_SW, 3'd1, 3'd6, 6'd63));     // store all ones at 126
    send_instr(enc_i(OPC_LW, 3'd1, 3'd2, 6'd63));
    send_instr(enc_i(OPC_LW, 3'd0, 3'd2, 6'd5));      // never stored, reads zero
    send_instr(enc_i(OPC_SW, 3'd6, 3'd1, 6'd1));      // all ones + 1 wraps to address 0
    send_instr(enc_i(OPC_LW, 3'd6, 3'd3, 6'd1));
    send_instr(enc_i(OPC_ADDI, 3'd1, 3'd0, 6'd5));    // register zero is writable
    send_instr(enc_i(OPC_BEQ, 3'd0, 3'd1, 6'd10));    // not taken
    send_instr(enc_i(OPC_BEQ, 3'd3, 3'd3, 6'd0));     // taken onto itself
    send_instr({OPC_JUMP, 5'h1F, 7'h7F});             // highest target
    send_instr(enc_i(OPC_BEQ, 3'd6, 3'd6, 6'd63));    // 127 -> 190
    send_instr(enc_i(OPC_BEQ, 3'd6, 3'd6, 6'd63));    // 190 -> 253
    send_instr(enc_i(OPC_ADDI, 3'd7, 3'd7, 6'd63));
    send_instr(enc_i(OPC_ADDI, 3'd7, 3'd7, 6'd63));
    send_instr(enc_i(OPC_ADDI, 3'd7, 3'd7, 6'd63));   // program counter wraps to 0
    send_instr({OPC_JUMP, 5'h00, 7'h00});             // lowest target
  endtask

  // Sequence: reset, the directed opening, then three random phases. The first phase
  // stalls the receiver heavily so the result queue backs up and full is exercised; the
  // second starves the block from the sender side; the third runs at full rate.
  initial begin
    tracker = new();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    run_directed();
    repeat (520) send_instr(random_instr());
    send_idle_pct = 60;
    recv_idle_pct = 12;
    repeat (515) send_instr(random_instr());
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (515) send_instr(random_instr());
    push <= 1'b0;
    // Drain every outstanding result, then give the block a few more cycles in case it
    // produces anything it should not.
    while (tracker.pending() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (tracker.mismatches == 0 && tracker.pending() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
design/mmis_pkg.sv
design/mmis_ram.sv
design/mmis_fifo.sv
design/mmis_front.sv
design/mmis_back.sv
design/mini_mips_instruction_step.sv
tb/sv/testbench.sv
